/* hw/rtl/qgram_profile_distance_macros.svh */
// Assertion macros for the q-gram profile distance block
`ifndef QGRAM_PROFILE_DISTANCE_MACROS_SVH
`define QGRAM_PROFILE_DISTANCE_MACROS_SVH
// Implication checked every clock outside reset
`define QPD_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset
`define QPD_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

/* hw/rtl/qpd_pkg.sv */
// Package: types, constants and commands for the q-gram profile distance block
package qpd_pkg;
    localparam int QMaxDef     = 8;
    localparam int EntriesDef  = 512;
    localparam int MaxLenDef   = 256;
    localparam int SymW        = 21;
    localparam int QlenW       = 4;
    localparam int CountW      = 9;
    localparam int DistW       = 10;
    localparam logic [QlenW-1:0] QlenReset = 4'd2;
    localparam logic [CountW-1:0] CountMax = '1;
    localparam logic [DistW-1:0]  DistMax  = '1;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SEARCH_RD,
        S_SEARCH_CMP,
        S_INSERT,
        S_CNT_RD,
        S_CNT_WR,
        S_SUM_RD,
        S_SUM_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic take;
        logic shift;
        logic gram_rd;
        logic idx_clear;
        logic idx_inc;
        logic insert;
        logic cnt_rd;
        logic cnt_wr;
        logic sum_clear;
        logic sum_acc;
        logic pair_end;
    } t_cmd;

    typedef struct packed {
        logic side_change;
        logic accept_sym;
        logic gram_ready;
        logic idx_at_fill;
        logic table_full;
        logic match;
        logic last;
    } t_status;
endpackage

/* hw/rtl/qpd_ram.sv */
// Generic single-port write, single-port registered-read RAM
module qpd_ram #(
    parameter int Width = 8,
    parameter int Depth = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(Depth)-1:0] i_waddr,
    input  logic [Width-1:0]         i_wdata,
    input  logic [$clog2(Depth)-1:0] i_raddr,
    output logic [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

/* hw/rtl/qpd_datapath.sv */
// Datapath: window, q-gram table, counts and distance accumulator
module qpd_datapath #(
    parameter int QMax    = qpd_pkg::QMaxDef,
    parameter int Entries = qpd_pkg::EntriesDef,
    parameter int MaxLen  = qpd_pkg::MaxLenDef
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [qpd_pkg::SymW-1:0]     i_symbol,
    input  logic                         i_symbol_valid,
    input  logic                         i_from_second,
    input  logic                         i_end_of_pair,
    input  logic                         i_cfg_we,
    input  logic [qpd_pkg::QlenW-1:0]    i_cfg_data,
    input  qpd_pkg::t_cmd                i_cmd,
    output qpd_pkg::t_status             o_status,
    output logic [qpd_pkg::DistW-1:0]    o_distance
);
    import qpd_pkg::*;

    localparam int IdxW  = $clog2(Entries);
    localparam int FillW = $clog2(Entries + 1);
    localparam int SeenW = $clog2(MaxLen + 1);
    localparam int GramW = QMax * SymW;
    localparam int QW    = $clog2(QMax + 1);
    localparam int WinW  = (QMax > 1) ? $clog2(QMax) : 1;

    logic [QlenW-1:0]   r_qlen;
    logic [SymW-1:0]    r_win [QMax];
    logic [SeenW-1:0]   r_seen;
    logic               r_side;
    logic [SymW-1:0]    r_sym;
    logic               r_valid;
    logic               r_last;
    logic [FillW-1:0]   r_fill;
    logic [FillW-1:0]   r_idx;
    logic [DistW-1:0]   r_dist;

    logic [QW-1:0]      q_eff;
    logic [GramW-1:0]   w_gram;
    logic [GramW-1:0]   w_rd_gram;
    logic [2*CountW-1:0] w_rd_cnt;
    logic [2*CountW-1:0] w_wr_cnt;
    logic               w_match;
    logic [IdxW-1:0]    w_idx;
    logic [CountW-1:0]  w_a;
    logic [CountW-1:0]  w_b;
    logic [CountW-1:0]  w_diff;
    logic [DistW:0]     w_sum;

    always_comb begin
        if (r_qlen == '0) begin
            q_eff = QW'(1);
        end else if (32'(r_qlen) > QMax) begin
            q_eff = QW'(QMax);
        end else begin
            q_eff = QW'(r_qlen);
        end
    end

    // aligned gram: slot k holds window[QMax-q+k] for k<q, zero above
    always_comb begin
        w_gram = '0;
        for (int k = 0; k < QMax; k++) begin
            if (k < 32'(q_eff)) begin
                w_gram[k*SymW +: SymW] = r_win[WinW'(QMax - 32'(q_eff) + k)];
            end
        end
    end

    always_comb begin
        w_match = 1'b1;
        for (int k = 0; k < QMax; k++) begin
            if (k < 32'(q_eff) &&
                w_rd_gram[k*SymW +: SymW] != w_gram[k*SymW +: SymW]) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_idx = r_idx[IdxW-1:0];

    qpd_ram #(.Width(GramW), .Depth(Entries)) u_gram_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.insert),
        .i_waddr (w_idx),
        .i_wdata (w_gram),
        .i_raddr (w_idx),
        .o_rdata (w_rd_gram)
    );

    always_comb begin
        w_a = w_rd_cnt[CountW-1:0];
        w_b = w_rd_cnt[2*CountW-1:CountW];
        w_wr_cnt = w_rd_cnt;
        if (r_side) begin
            if (w_b != CountMax) w_wr_cnt[2*CountW-1:CountW] = w_b + 1'b1;
        end else begin
            if (w_a != CountMax) w_wr_cnt[CountW-1:0] = w_a + 1'b1;
        end
        if (i_cmd.insert) begin
            w_wr_cnt = r_side ? {CountW'(1), CountW'(0)} : {CountW'(0), CountW'(1)};
        end
        w_diff = (w_a > w_b) ? (w_a - w_b) : (w_b - w_a);
        w_sum  = {1'b0, r_dist} + (DistW+1)'(w_diff);
    end

    qpd_ram #(.Width(2*CountW), .Depth(Entries)) u_count_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.cnt_wr || i_cmd.insert),
        .i_waddr (w_idx),
        .i_wdata (w_wr_cnt),
        .i_raddr (w_idx),
        .o_rdata (w_rd_cnt)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_qlen <= QlenReset;
        end else if (i_cfg_we) begin
            r_qlen <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_sym   <= i_symbol;
            r_valid <= i_symbol_valid;
            r_last  <= i_end_of_pair;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen <= '0;
            r_side <= 1'b0;
            r_fill <= '0;
            r_idx  <= '0;
            r_dist <= '0;
            for (int k = 0; k < QMax; k++) r_win[k] <= '0;
        end else begin
            if (i_cmd.take && i_from_second != r_side) begin
                r_side <= i_from_second;
                r_seen <= '0;
                for (int k = 0; k < QMax; k++) r_win[k] <= '0;
            end
            if (i_cmd.shift) begin
                for (int k = 0; k < QMax - 1; k++) r_win[k] <= r_win[k+1];
                r_win[QMax-1] <= r_sym;
                r_seen <= r_seen + 1'b1;
            end
            if (i_cmd.idx_clear) begin
                r_idx <= '0;
            end else if (i_cmd.idx_inc) begin
                r_idx <= r_idx + 1'b1;
            end
            if (i_cmd.insert) begin
                r_fill <= r_fill + 1'b1;
            end
            if (i_cmd.sum_clear) begin
                r_dist <= '0;
            end else if (i_cmd.sum_acc) begin
                r_dist <= w_sum[DistW] ? DistMax : w_sum[DistW-1:0];
            end
            if (i_cmd.pair_end) begin
                r_fill <= '0;
                r_side <= 1'b0;
                r_seen <= '0;
                for (int k = 0; k < QMax; k++) r_win[k] <= '0;
            end
        end
    end

    assign o_status.side_change = i_from_second != r_side;
    assign o_status.accept_sym  = r_valid && (32'(r_seen) < MaxLen);
    assign o_status.gram_ready  = 32'(r_seen) >= 32'(q_eff);
    assign o_status.idx_at_fill = r_idx == r_fill;
    assign o_status.table_full  = 32'(r_fill) >= Entries;
    assign o_status.match       = w_match;
    assign o_status.last        = r_last;
    assign o_distance           = r_dist;
endmodule

/* hw/rtl/qpd_ctrl.sv */
// Controller: sequences lookup, counting, distance sum and output
module qpd_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  qpd_pkg::t_status  i_status,
    output qpd_pkg::t_cmd     o_cmd
);
    import qpd_pkg::*;

    t_state r_state;
    t_state n_state;
    logic   r_sym_done;
    logic   n_sym_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_sym_done <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_sym_done <= n_sym_done;
        end
    end

    // r_sym_done: symbol shifted in, ready to decide on gram
    always_comb begin
        n_state    = r_state;
        n_sym_done = r_sym_done;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    n_state    = S_SEARCH_RD;
                    n_sym_done = 1'b0;
                end
            end
            S_SEARCH_RD: begin
                if (!r_sym_done) begin
                    n_sym_done = 1'b1;
                    if (!i_status.accept_sym) begin
                        n_state = S_SUM_RD;
                    end
                end else if (!i_status.gram_ready) begin
                    n_state = S_SUM_RD;
                end else if (i_status.idx_at_fill) begin
                    n_state = i_status.table_full ? S_SUM_RD : S_INSERT;
                end else begin
                    n_state = S_SEARCH_CMP;
                end
            end
            S_SEARCH_CMP: n_state = i_status.match ? S_CNT_WR : S_SEARCH_RD;
            S_INSERT:     n_state = S_SUM_RD;
            S_CNT_RD:     n_state = S_CNT_WR;
            S_CNT_WR:     n_state = S_SUM_RD;
            S_SUM_RD: begin
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (i_status.idx_at_fill) begin
                    n_state = S_OUT;
                end else begin
                    n_state = S_SUM_ACC;
                end
            end
            S_SUM_ACC: n_state = i_status.idx_at_fill ? S_OUT : S_SUM_ACC;
            S_OUT:     if (i_out_ready) n_state = S_IDLE;
            default:   n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.take    = i_in_valid;
                o_cmd.idx_clear = 1'b1;
            end
            S_SEARCH_RD: begin
                if (!r_sym_done) begin
                    o_cmd.shift = i_status.accept_sym;
                    o_cmd.idx_clear = 1'b1;
                    if (!i_status.accept_sym) o_cmd.sum_clear = 1'b1;
                end else if (!i_status.gram_ready || i_status.idx_at_fill) begin
                    o_cmd.sum_clear = !i_status.gram_ready ||
                                      i_status.table_full;
                    if (!i_status.gram_ready || i_status.table_full)
                        o_cmd.idx_clear = 1'b1;
                end
            end
            S_SEARCH_CMP: begin
                if (!i_status.match) o_cmd.idx_inc = 1'b1;
            end
            S_INSERT: begin
                o_cmd.insert    = 1'b1;
                o_cmd.idx_clear = 1'b1;
                o_cmd.sum_clear = 1'b1;
            end
            S_CNT_RD: begin
            end
            S_CNT_WR: begin
                o_cmd.cnt_wr    = 1'b1;
                o_cmd.idx_clear = 1'b1;
                o_cmd.sum_clear = 1'b1;
            end
            S_SUM_RD: begin
                o_cmd.gram_rd = 1'b1;
                if (i_status.last && !i_status.idx_at_fill) o_cmd.idx_inc = 1'b1;
            end
            S_SUM_ACC: begin
                o_cmd.sum_acc = 1'b1;
                if (!i_status.idx_at_fill) o_cmd.idx_inc = 1'b1;
            end
            S_OUT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) o_cmd.pair_end = 1'b1;
            end
            default: ;
        endcase
    end
endmodule

/* hw/rtl/qgram_profile_distance.sv */
// Operation: a q-gram lookup scans the filled entries, each through a read state and
// a compare state (S_SEARCH_RD, S_SEARCH_CMP), then counts the gram, inserting it if
// new and the table has room; a pair-end request adds a distance sum over the filled
// entries, plus output stalls.
// One request in flight at a time; the next is accepted once the block is idle.
// Reset (synchronous, active low) empties the table and sets q to 2.
module qgram_profile_distance #(
    parameter int QMax    = qpd_pkg::QMaxDef,
    parameter int Entries = qpd_pkg::EntriesDef,
    parameter int MaxLen  = qpd_pkg::MaxLenDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,  // symbol[20:0], zero fill
    input  logic [1:0]  s_axis_tuser,  // symbol_valid, from_second
    input  logic        s_axis_tlast,  // end_of_pair
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,  // distance[9:0], zero fill
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_data
);
    import qpd_pkg::*;
    `include "qgram_profile_distance_macros.svh"

    t_cmd    w_cmd;
    t_status w_status;
    logic [DistW-1:0] w_dist;

    qpd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_status    (w_status),
        .o_cmd       (w_cmd)
    );

    qpd_datapath #(.QMax(QMax), .Entries(Entries), .MaxLen(MaxLen)) u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_symbol       (s_axis_tdata[20:0]),
        .i_symbol_valid (s_axis_tuser[0]),
        .i_from_second  (s_axis_tuser[1]),
        .i_end_of_pair  (s_axis_tlast),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_data     (i_cfg_data),
        .i_cmd          (w_cmd),
        .o_status       (w_status),
        .o_distance     (w_dist)
    );

    assign m_axis_tdata = {6'd0, w_dist};

    `QPD_ASSERT_IMP(a_no_in_while_out, i_clk, i_rst_n, m_axis_tvalid, !s_axis_tready)
    `QPD_ASSERT_IMP(a_insert_not_full, i_clk, i_rst_n, w_cmd.insert, !w_status.table_full)
    `QPD_ASSERT_NXT(a_end_clears, i_clk, i_rst_n, w_cmd.pair_end, s_axis_tready)
endmodule

/* dv/qgram_profile_distance_test.sv */
// Self-checking testbench for the q-gram profile distance block
module qgram_profile_distance_test;
    import qpd_pkg::*;

    localparam int QMAX = QMaxDef;
    localparam int ENTRIES = EntriesDef;
    localparam int MAXLEN = MaxLenDef;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata;
    logic [1:0]  s_axis_tuser;
    logic        s_axis_tlast;
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [15:0] m_axis_tdata;
    logic        i_cfg_we;
    logic [3:0]  i_cfg_data;

    qgram_profile_distance dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .s_axis_tlast(s_axis_tlast),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .i_cfg_we(i_cfg_we), .i_cfg_data(i_cfg_data)
    );

    // predictor state
    logic [SymW-1:0]   gram_tab [ENTRIES][QMAX];
    logic [CountW-1:0] cnt_a [ENTRIES];
    logic [CountW-1:0] cnt_b [ENTRIES];
    int                n_grams;
    logic [SymW-1:0]   win [QMAX];
    int                n_syms;
    logic              side_now;
    logic [QlenW-1:0]  qlen_reg;

    logic [DistW-1:0]  dist_q [$];
    int                errors;
    int                mismatches;
    int                send_idle_pct;
    int                recv_idle_pct;

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    initial begin
        #40000000;
        $display("qgram_profile_distance_test NOT OK");
        $finish;
    end

    function automatic int eff_q();
        if (qlen_reg == 0) return 1;
        if (qlen_reg > QMAX) return QMAX;
        return int'(qlen_reg);
    endfunction

    task automatic predictor_clear();
        n_grams = 0;
        for (int k = 0; k < QMAX; k++) win[k] = '0;
        n_syms = 0;
        side_now = 1'b0;
    endtask

    task automatic predict_item(logic [SymW-1:0] sym, logic vld, logic sd, logic last);
        int q;
        int e;
        bit hit;
        int acc;
        q = eff_q();
        if (sd != side_now) begin
            side_now = sd;
            for (int k = 0; k < QMAX; k++) win[k] = '0;
            n_syms = 0;
        end
        if (vld && n_syms < MAXLEN) begin
            for (int k = 0; k < QMAX - 1; k++) win[k] = win[k+1];
            win[QMAX-1] = sym;
            n_syms++;
            if (n_syms >= q) begin
                e = 0;
                hit = 0;
                while (e < n_grams && !hit) begin
                    hit = 1;
                    for (int k = 0; k < q; k++)
                        if (gram_tab[e][k] != win[QMAX-q+k]) hit = 0;
                    if (!hit) e++;
                end
                if (!hit && n_grams < ENTRIES) begin
                    for (int k = 0; k < QMAX; k++)
                        gram_tab[e][k] = (k < q) ? win[QMAX-q+k] : '0;
                    cnt_a[e] = '0;
                    cnt_b[e] = '0;
                    n_grams++;
                    hit = 1;
                end
                if (hit) begin
                    if (side_now) begin
                        if (cnt_b[e] != CountMax) cnt_b[e]++;
                    end else begin
                        if (cnt_a[e] != CountMax) cnt_a[e]++;
                    end
                end
            end
        end
        if (last) begin
            acc = 0;
            for (int i = 0; i < n_grams; i++) begin
                acc += (cnt_a[i] > cnt_b[i]) ? int'(cnt_a[i] - cnt_b[i])
                                             : int'(cnt_b[i] - cnt_a[i]);
                if (acc > int'(DistMax)) acc = int'(DistMax);
            end
            dist_q.push_back(DistW'(acc));
            predictor_clear();
        end
    endtask

    task automatic send_symbol(logic [SymW-1:0] sym, logic vld, logic sd, logic last);
        while (send_idle_pct > 0 && $urandom_range(99, 0) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'd0, sym};
        s_axis_tuser  <= {sd, vld};
        s_axis_tlast  <= last;
        predict_item(sym, vld, sd, last);
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (m_axis_tvalid && m_axis_tready) begin
                if (dist_q.size() == 0) begin
                    errors++;
                    if (mismatches++ < 10)
                        $display("unexpected distance %0d", m_axis_tdata[DistW-1:0]);
                end else begin
                    if (m_axis_tdata[DistW-1:0] !== dist_q[0]) begin
                        errors++;
                        if (mismatches++ < 10)
                            $display("distance mismatch: expected %0d, got %0d",
                                     dist_q[0], m_axis_tdata[DistW-1:0]);
                    end
                    void'(dist_q.pop_front());
                end
            end
            m_axis_tready <= !(recv_idle_pct > 0 && $urandom_range(99, 0) < recv_idle_pct);
        end
    end

    task automatic wait_idle();
        int guard;
        guard = 0;
        s_axis_tvalid <= 1'b0;
        while (dist_q.size() != 0 && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        if (dist_q.size() != 0) begin
            $display("qgram_profile_distance_test NOT OK");
            $finish;
        end
        repeat (ENTRIES * 3 + 50) @(posedge i_clk);
    endtask

    task automatic write_qlen(logic [QlenW-1:0] v);
        wait_idle();
        i_cfg_we   <= 1'b1;
        i_cfg_data <= v;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        qlen_reg = v;
    endtask

    task automatic send_string(int len, logic sd, int alpha, logic last_here);
        for (int i = 0; i < len; i++)
            send_symbol(SymW'($urandom_range(alpha - 1, 0)), 1'b1, sd,
                        last_here && i == len - 1);
    endtask

    task automatic test_directed();
        // extremes of symbol, empty pair, marker-only pair
        send_symbol(21'h1FFFFF, 1, 0, 0);
        send_symbol(21'h000000, 1, 0, 0);
        send_symbol(21'h10FFFF, 1, 0, 0);
        send_symbol(21'h1FFFFF, 1, 1, 0);
        send_symbol(21'h000000, 1, 1, 1);
        send_symbol(21'h155555, 0, 0, 1);
        send_symbol(21'h0AAAAA, 0, 1, 1);
        // second string only, then return to first string
        send_string(3, 1, 4, 0);
        send_string(3, 0, 4, 0);
        send_string(2, 1, 4, 0);
        send_symbol(21'h3, 1, 0, 1);
        // short string
        send_symbol(21'h7, 1, 0, 0);
        send_symbol(21'h7, 1, 1, 1);
    endtask

    task automatic test_random_pairs(int pairs);
        int la, lb, alpha;
        for (int p = 0; p < pairs; p++) begin
            alpha = ($urandom_range(3, 0) == 0) ? (1 << 21) : $urandom_range(4, 1);
            la = $urandom_range(10, 0);
            lb = $urandom_range(10, 0);
            if ($urandom_range(9, 0) == 0) begin
                send_symbol(SymW'($urandom), $urandom_range(1, 0), $urandom_range(1, 0), 1);
            end else begin
                send_string(la, 0, alpha, 0);
                if ($urandom_range(4, 0) == 0)
                    send_symbol(SymW'($urandom), 0, 0, 0);
                send_string(lb, 1, alpha, 0);
                send_symbol(SymW'($urandom_range(alpha - 1, 0)), $urandom_range(1, 0),
                            1, 1);
            end
        end
    endtask

    task automatic test_saturation();
        // long repeated string: length cap
        send_string(260, 0, 1, 0);
        send_symbol(21'h0, 1, 1, 1);
        // distinct grams on both sides
        for (int i = 0; i < 30; i++) send_symbol(SymW'(i), 1, 0, 0);
        for (int i = 0; i < 30; i++) send_symbol(SymW'(i + 1000), 1, 1, i == 29);
    endtask

    initial begin
        i_rst_n = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = '0;
        s_axis_tlast = 1'b0;
        m_axis_tready = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_data = '0;
        errors = 0;
        mismatches = 0;
        send_idle_pct = 34;
        recv_idle_pct = 63;
        qlen_reg = QlenReset;
        predictor_clear();
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed();
        write_qlen(4'd1);
        test_directed();
        test_random_pairs(5);
        send_idle_pct = 63;
        recv_idle_pct = 34;
        write_qlen(4'd8);
        test_random_pairs(5);
        write_qlen(4'd0);
        test_random_pairs(4);
        write_qlen(4'd15);
        test_random_pairs(4);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        write_qlen(4'd3);
        test_random_pairs(6);
        write_qlen(4'd1);
        test_saturation();
        wait_idle();

        if (errors == 0) begin
            $display("qgram_profile_distance_test OK");
        end else begin
            $display("qgram_profile_distance_test NOT OK");
        end
        $finish;
    end
endmodule
